[hdl/chtr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the chained hash table core
// no dependencies
package chtr_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int INVAL_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 32;
    localparam int SIZE_W   = 4;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 4;

    // golden ratio fraction in 0.32 fixed point
    localparam logic [KEY_W-1:0] GOLDEN_MUL = 32'h9E37_79B9;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_INS_POP,
        S_INS_BKT,
        S_LK_RD,
        S_LK_H,
        S_LK_N,
        S_LK_W,
        S_WALK_H,
        S_WALK,
        S_WALK_D,
        S_DEL_UNLINK,
        S_DEL_CHK,
        S_RH_CLR,
        S_RH_BKT,
        S_RH_HD,
        S_RH_ND,
        S_RH_HASH,
        S_RH_ADV,
        S_RESP
    } t_state;

endpackage

[hdl/chained_hash_table_resizing_core.sv]
`timescale 1ns / 1ps
// chained hash table with automatic resizing, top level and sequencer
// depends on chtr_pkg, chtr_ram, chtr_free_stack
//
// Separate-chaining hash table over a pool of MAX_NODES nodes. Each input
// transaction inserts, deletes or searches a 32-bit key; one result
// transaction follows every input. The bucket is the top size_log2 bits of
// the low word of key * 0x9E3779B9. Bucket heads live in a two-bank memory
// so a resize rebuilds into the idle bank. The sequencer does one memory
// access per step: a search reads the bucket head and then the key, value
// and link of each chain node visited; a delete walks the same way and
// unlinks the node when it hits; an insert pops a free node, writes its key
// and value and links it after the bucket head (as the head of an empty
// bucket); a full pool or an unused command answers directly. A resize
// clears the target bank, reads each old bucket head and relinks every
// moved node into the target bank. The input is ready again the cycle after
// the result is loaded; a result still waiting in the output register holds
// the core in its response state. After reset and after every configuration
// write a clearing pass over both head banks runs while no input is
// accepted. A configuration write clears the table and loads the new size
// (clipped to MAX_BUCKETS_LOG2).
module chained_hash_table_resizing_core
    import chtr_pkg::*;
#(
    parameter int MAX_BUCKETS_LOG2 = 10,
    parameter int MAX_NODES        = 1024,
    parameter int VALUE_BITS       = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: initial_size_log2
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // input: [1:0] command, [33:2] key, [65:34] value, rest zero
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [71:0]      i_s_tdata,
    // output: [2:0] status, [34:3] found_value, [38:35] table_size_log2,
    // [49:39] entry_count, rest zero
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [55:0]      o_m_tdata
);

    localparam int BA  = MAX_BUCKETS_LOG2;
    localparam int HAW = BA + 1;
    localparam int NP  = $clog2(MAX_NODES + 1);
    localparam int NI  = $clog2(MAX_NODES);
    localparam int LW  = $clog2(MAX_BUCKETS_LOG2 + 1);
    localparam int KVW = KEY_W + VALUE_BITS;
    localparam logic [NP-1:0] NIL = NP'(MAX_NODES);

    // bucket of a hash for a table of 2^lg buckets
    function automatic logic [BA-1:0] f_bucket(input logic [KEY_W-1:0] h,
                                               input logic [LW-1:0] lg);
        logic [KEY_W-1:0] s;
        s = h >> (6'd32 - 6'(lg));
        if (lg == '0) begin
            return '0;
        end
        return s[BA-1:0];
    endfunction

    // ---------------- state registers ----------------
    t_state r_state, n_state;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [KEY_W-1:0]      r_hash, n_hash;       // hash of the item key
    logic [KEY_W-1:0]      r_rh_hash, n_rh_hash; // hash of a moved node
    logic                  r_bank, n_bank;       // live head bank
    logic [LW-1:0]         r_lg, n_lg;
    logic [NP-1:0]         r_count, n_count;
    logic [NP-1:0]         r_ftop, n_ftop;
    logic [NP-1:0]         r_cur, n_cur;
    logic [NP-1:0]         r_prev, n_prev;
    logic [NP-1:0]         r_nxt, n_nxt;
    logic [NP-1:0]         r_node, n_node;       // node taken for insert
    logic [NP-1:0]         r_lk_node, n_lk_node;
    logic [HAW-1:0]        r_lk_addr, n_lk_addr;
    logic                  r_lk_rh, n_lk_rh;     // link called from rehash
    logic [BA-1:0]         r_bucket, n_bucket;
    logic [HAW-1:0]        r_clr, n_clr;
    logic [HAW-1:0]        r_rh_i, n_rh_i;
    logic [HAW-1:0]        r_rh_lim, n_rh_lim;
    logic [LW-1:0]         r_rh_lg, n_rh_lg;
    logic                  r_rh_ins, n_rh_ins;   // rehash was for an insert
    logic [NP-1:0]         r_rh_n, n_rh_n;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [FOUND_W-1:0]    r_found, n_found;

    // output register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [FOUND_W-1:0]    r_o_found;
    logic [SIZE_W-1:0]     r_o_size;
    logic [COUNT_W-1:0]    r_o_count;
    logic                  out_load;

    // ---------------- memories ----------------
    logic           head_we, head_re;
    logic [HAW-1:0] head_waddr, head_raddr;
    logic [NP-1:0]  head_wdata, head_rdata;
    logic           kv_we, kv_re;
    logic [NI-1:0]  kv_waddr, kv_raddr;
    logic [KVW-1:0] kv_wdata, kv_rdata;
    logic           nx_we, nx_re;
    logic [NI-1:0]  nx_waddr, nx_raddr;
    logic [NP-1:0]  nx_wdata, nx_rdata;
    logic           fs_we, fs_re;
    logic [NI-1:0]  fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    chtr_ram #(.WIDTH(NP), .DEPTH(1 << HAW)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(head_re), .i_raddr(head_raddr), .o_rdata(head_rdata)
    );

    chtr_ram #(.WIDTH(KVW), .DEPTH(MAX_NODES)) u_kv (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(kv_wdata),
        .i_re(kv_re), .i_raddr(kv_raddr), .o_rdata(kv_rdata)
    );

    chtr_ram #(.WIDTH(NP), .DEPTH(MAX_NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(nx_re), .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    chtr_free_stack #(.MAX_NODES(MAX_NODES)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cfg_we),
        .i_rd_en(fs_re), .i_rd_addr(fs_raddr), .o_rd_data(fs_rdata),
        .i_wr_en(fs_we), .i_wr_addr(fs_waddr), .i_wr_data(fs_wdata)
    );

    // ---------------- datapath helpers ----------------
    logic                  s_acc;
    logic [KEY_W-1:0]      in_key, kv_key, mul_a, mul_p;
    logic [VALUE_BITS-1:0] in_val, kv_val;
    logic [63:0]           kv_val64;
    logic [31:0]           size_n;
    logic [LW-1:0]         cfg_lg;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_key     = i_s_tdata[33:2];
    assign in_val     = VALUE_BITS'(64'(i_s_tdata[65:34]));
    assign kv_key     = kv_rdata[KEY_W-1:0];
    assign kv_val     = kv_rdata[KVW-1:KEY_W];
    assign kv_val64   = 64'(kv_val);
    assign size_n     = 32'd1 << r_lg;
    assign cfg_lg     = (32'(i_cfg_wdata) > MAX_BUCKETS_LOG2) ?
                        LW'(MAX_BUCKETS_LOG2) : LW'(i_cfg_wdata);

    // the one multiplier: item key on accept, node key during rehash
    assign mul_a = (r_state == S_RH_ND) ? kv_key : in_key;
    assign mul_p = mul_a * GOLDEN_MUL;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_hash    = r_hash;
        n_rh_hash = r_rh_hash;
        n_bank    = r_bank;
        n_lg      = r_lg;
        n_count   = r_count;
        n_ftop    = r_ftop;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_nxt     = r_nxt;
        n_node    = r_node;
        n_lk_node = r_lk_node;
        n_lk_addr = r_lk_addr;
        n_lk_rh   = r_lk_rh;
        n_bucket  = r_bucket;
        n_clr     = r_clr;
        n_rh_i    = r_rh_i;
        n_rh_lim  = r_rh_lim;
        n_rh_lg   = r_rh_lg;
        n_rh_ins  = r_rh_ins;
        n_rh_n    = r_rh_n;
        n_status  = r_status;
        n_found   = r_found;
        out_load  = 1'b0;

        head_we = 1'b0; head_waddr = '0; head_wdata = NIL;
        head_re = 1'b0; head_raddr = '0;
        kv_we   = 1'b0; kv_waddr   = '0; kv_wdata   = {r_val, r_key};
        kv_re   = 1'b0; kv_raddr   = '0;
        nx_we   = 1'b0; nx_waddr   = '0; nx_wdata   = NIL;
        nx_re   = 1'b0; nx_raddr   = '0;
        fs_we   = 1'b0; fs_waddr   = '0; fs_wdata   = '0;
        fs_re   = 1'b0; fs_raddr   = '0;

        case (r_state)
            // clear both head banks after reset or a size write
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd   = i_s_tdata[1:0];
                    n_key   = in_key;
                    n_val   = in_val;
                    n_hash  = mul_p;
                    n_found = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_bucket = f_bucket(r_hash, r_lg);
                case (r_cmd)
                    CMD_INSERT: begin
                        if (r_ftop == '0) begin
                            n_status = ST_POOL_FULL;
                            n_state  = S_RESP;
                        end else begin
                            fs_re    = 1'b1;
                            fs_raddr = NI'(r_ftop - 1'b1);
                            n_ftop   = r_ftop - 1'b1;
                            n_count  = r_count + 1'b1;
                            n_state  = S_INS_POP;
                        end
                    end
                    CMD_DELETE, CMD_SEARCH: begin
                        head_re    = 1'b1;
                        head_raddr = {r_bank, f_bucket(r_hash, r_lg)};
                        n_prev     = NIL;
                        n_state    = S_WALK_H;
                    end
                    default: begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_INS_POP: begin
                n_node = NP'(fs_rdata);
                // grow first when the new count passes the bucket count
                if ((32'(r_count) > size_n) && (32'(r_lg) < MAX_BUCKETS_LOG2)) begin
                    n_rh_lg  = r_lg + 1'b1;
                    n_rh_lim = HAW'(1) << r_lg;
                    n_rh_ins = 1'b1;
                    n_clr    = '0;
                    n_state  = S_RH_CLR;
                end else begin
                    n_state = S_INS_BKT;
                end
            end
            S_INS_BKT: begin
                kv_we     = 1'b1;
                kv_waddr  = r_node[NI-1:0];
                n_lk_node = r_node;
                n_lk_addr = {r_bank, f_bucket(r_hash, r_lg)};
                n_lk_rh   = 1'b0;
                n_state   = S_LK_RD;
            end
            // link r_lk_node as the head of an empty bucket r_lk_addr, else right after its head
            S_LK_RD: begin
                head_re    = 1'b1;
                head_raddr = r_lk_addr;
                n_state    = S_LK_H;
            end
            S_LK_H: begin
                if (head_rdata == NIL) begin
                    head_we    = 1'b1;
                    head_waddr = r_lk_addr;
                    head_wdata = r_lk_node;
                    nx_we      = 1'b1;
                    nx_waddr   = r_lk_node[NI-1:0];
                    nx_wdata   = NIL;
                    if (r_lk_rh) begin
                        n_state = S_RH_ADV;
                    end else begin
                        n_status = ST_INSERTED;
                        n_state  = S_RESP;
                    end
                end else begin
                    nx_re    = 1'b1;
                    nx_raddr = head_rdata[NI-1:0];
                    n_cur    = head_rdata;
                    n_state  = S_LK_N;
                end
            end
            S_LK_N: begin
                nx_we    = 1'b1;
                nx_waddr = r_lk_node[NI-1:0];
                nx_wdata = nx_rdata;
                n_state  = S_LK_W;
            end
            S_LK_W: begin
                nx_we    = 1'b1;
                nx_waddr = r_cur[NI-1:0];
                nx_wdata = r_lk_node;
                if (r_lk_rh) begin
                    n_state = S_RH_ADV;
                end else begin
                    n_status = ST_INSERTED;
                    n_state  = S_RESP;
                end
            end
            // chain walk for delete and search
            S_WALK_H: begin
                n_cur   = head_rdata;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_cur == NIL) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    kv_re    = 1'b1;
                    kv_raddr = r_cur[NI-1:0];
                    nx_re    = 1'b1;
                    nx_raddr = r_cur[NI-1:0];
                    n_state  = S_WALK_D;
                end
            end
            S_WALK_D: begin
                if (kv_key == r_key) begin
                    if (r_cmd == CMD_SEARCH) begin
                        n_status = ST_FOUND;
                        n_found  = kv_val64[FOUND_W-1:0];
                        n_state  = S_RESP;
                    end else begin
                        n_nxt   = nx_rdata;
                        n_state = S_DEL_UNLINK;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = nx_rdata;
                    n_state = S_WALK;
                end
            end
            S_DEL_UNLINK: begin
                if (r_prev == NIL) begin
                    head_we    = 1'b1;
                    head_waddr = {r_bank, r_bucket};
                    head_wdata = r_nxt;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = r_prev[NI-1:0];
                    nx_wdata = r_nxt;
                end
                fs_we    = 1'b1;
                fs_waddr = r_ftop[NI-1:0];
                fs_wdata = r_cur[NI-1:0];
                n_ftop   = r_ftop + 1'b1;
                n_count  = r_count - 1'b1;
                n_state  = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                n_status = ST_DELETED;
                if ((r_lg != '0) && (32'(r_count) < (size_n >> 2))) begin
                    n_rh_lg  = r_lg - 1'b1;
                    n_rh_lim = HAW'(1) << r_lg;
                    n_rh_ins = 1'b0;
                    n_clr    = '0;
                    n_state  = S_RH_CLR;
                end else begin
                    n_state = S_RESP;
                end
            end
            // rehash into the idle bank
            S_RH_CLR: begin
                head_we    = 1'b1;
                head_waddr = {~r_bank, r_clr[BA-1:0]};
                n_clr      = r_clr + 1'b1;
                if (r_clr[BA-1:0] == '1) begin
                    n_rh_i  = '0;
                    n_state = S_RH_BKT;
                end
            end
            S_RH_BKT: begin
                if (r_rh_i == r_rh_lim) begin
                    n_bank  = ~r_bank;
                    n_lg    = r_rh_lg;
                    n_state = r_rh_ins ? S_INS_BKT : S_RESP;
                end else begin
                    head_re    = 1'b1;
                    head_raddr = {r_bank, r_rh_i[BA-1:0]};
                    n_state    = S_RH_HD;
                end
            end
            S_RH_HD: begin
                if (head_rdata == NIL) begin
                    n_rh_i  = r_rh_i + 1'b1;
                    n_state = S_RH_BKT;
                end else begin
                    n_rh_n   = head_rdata;
                    kv_re    = 1'b1;
                    kv_raddr = head_rdata[NI-1:0];
                    nx_re    = 1'b1;
                    nx_raddr = head_rdata[NI-1:0];
                    n_state  = S_RH_ND;
                end
            end
            S_RH_ND: begin
                n_nxt     = nx_rdata;
                n_rh_hash = mul_p;
                n_lk_node = r_rh_n;
                n_state   = S_RH_HASH;
            end
            S_RH_HASH: begin
                n_lk_addr = {~r_bank, f_bucket(r_rh_hash, r_rh_lg)};
                n_lk_rh   = 1'b1;
                n_state   = S_LK_RD;
            end
            S_RH_ADV: begin
                if (r_nxt == NIL) begin
                    n_rh_i  = r_rh_i + 1'b1;
                    n_state = S_RH_BKT;
                end else begin
                    n_rh_n   = r_nxt;
                    kv_re    = 1'b1;
                    kv_raddr = r_nxt[NI-1:0];
                    nx_re    = 1'b1;
                    nx_raddr = r_nxt[NI-1:0];
                    n_state  = S_RH_ND;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a size write clears the table and restarts the clearing pass
        if (i_cfg_we) begin
            n_lg    = cfg_lg;
            n_count = '0;
            n_ftop  = NP'(MAX_NODES);
            n_bank  = 1'b0;
            n_clr   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_lg    <= LW'(1);
            r_count <= '0;
            r_ftop  <= NP'(MAX_NODES);
            r_bank  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_lg    <= n_lg;
            r_count <= n_count;
            r_ftop  <= n_ftop;
            r_bank  <= n_bank;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_val     <= n_val;
        r_hash    <= n_hash;
        r_rh_hash <= n_rh_hash;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_nxt     <= n_nxt;
        r_node    <= n_node;
        r_lk_node <= n_lk_node;
        r_lk_addr <= n_lk_addr;
        r_lk_rh   <= n_lk_rh;
        r_bucket  <= n_bucket;
        r_rh_i    <= n_rh_i;
        r_rh_lim  <= n_rh_lim;
        r_rh_lg   <= n_rh_lg;
        r_rh_ins  <= n_rh_ins;
        r_rh_n    <= n_rh_n;
        r_status  <= n_status;
        r_found   <= n_found;
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_size   <= SIZE_W'(r_lg);
            r_o_count  <= COUNT_W'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_o_count, r_o_size, r_o_found, r_o_status};

    // ---------------- assertions ----------------
    // every node is either on the free stack or stored
    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_ftop) + 32'(r_count)) == MAX_NODES)
        else $error("free stack and entry count out of balance");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lg) <= MAX_BUCKETS_LOG2)
        else $error("table size beyond limit");

    // an accepted transaction goes straight to dispatch
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_cfg_we) |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

    // the live bank flips exactly when a rehash completes
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RH_BKT && r_rh_i == r_rh_lim && !i_cfg_we)
        |=> (r_bank != $past(r_bank)))
        else $error("rehash finished without bank swap");

endmodule

[hdl/chtr_ram.sv]
`timescale 1ns / 1ps
// simple dual port synchronous ram, one write and one read port
// registered read data; no dependencies
module chtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/chtr_free_stack.sv]
`timescale 1ns / 1ps
// free node stack; entries below the low-water mark were never written
// and read as their initial index; uses chtr_ram
module chtr_free_stack #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_rd_addr,
    output logic [$clog2(MAX_NODES)-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_NODES)-1:0] i_wr_data
);

    localparam int NI = $clog2(MAX_NODES);
    localparam int NP = $clog2(MAX_NODES + 1);
    localparam logic [NI-1:0] TOP_IDX = NI'(MAX_NODES - 1);

    logic [NP-1:0] r_low;
    logic          r_use_init;
    logic [NI-1:0] r_init_val;
    logic [NI-1:0] ram_rdata;

    chtr_ram #(.WIDTH(NI), .DEPTH(MAX_NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    // lowest stack position ever popped to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_low <= NP'(MAX_NODES);
        end else if (i_rd_en && (NP'(i_rd_addr) < r_low)) begin
            r_low <= NP'(i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_use_init <= NP'(i_rd_addr) < r_low;
            r_init_val <= TOP_IDX - i_rd_addr;
        end
    end

    assign o_rd_data = r_use_init ? r_init_val : ram_rdata;

endmodule
